### hdl/dbn_pkg.sv
package dbn_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int UNIT_W = 16;

  // Internal widths
  localparam int PROD_W = 49;   // signed Q16.16 times unsigned Q8.8
  localparam int DIFF_W = 33;   // b - a
  localparam int VSUM_W = 50;   // blended component, signed
  localparam int MAG_W = 49;    // magnitude of a blended component
  localparam int NORM_W = 31;   // magnitude after normalizing shift
  localparam int SHIFT_W = 5;
  localparam int SQ_W = 62;     // square of a normalized magnitude
  localparam int SUM_W = 64;    // sum of three squares
  localparam int QUO_W = 31;    // floor(2^30 * n^2 / S), at most 2^30
  localparam int ROOT_ACC_W = 32;
  localparam int ROOT_W = 16;   // isqrt of the quotient, at most 2^15
  localparam int MAGC_W = 15;   // rounded component magnitude, at most 16384

  // Pipeline shape
  localparam int DIV_STEPS = QUO_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int LANE_LAT = DIV_STEPS + ROOT_STEPS;
  localparam int FRONT_STAGES = 5;
  localparam int PIPE_DEPTH = FRONT_STAGES + LANE_LAT;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

  // Configuration register indexes
  localparam logic REG_WEIGHT_A = 1'b0;
  localparam logic REG_WEIGHT_B = 1'b1;

  localparam logic OP_BLEND = 1'b0;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
  } in_item_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic                     degenerate;
  } out_item_t;

  // Per-item flags that ride alongside the arithmetic lanes
  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
  } side_t;

endpackage

### hdl/direction_blend_normalizer.sv
// Direction blend normalizer. Each item carries two signed Q16.16 vectors and
// an op: blend (a*weight_a + b*weight_b) or difference (b - a). The block
// returns that vector scaled to unit length in signed Q2.14, each component
// rounded to nearest, with degenerate set and zero components when the
// vector is zero or, in blend mode, both weights are zero. One item enters
// per clock while in_ready is high. Each component lane holds a 31-step
// restoring divider and a 16-step square root. The whole pipeline advances
// together whenever the output register is empty or being taken, so
// in_ready drops only while a result sits unread.
// weight_a/weight_b (index 0/1) reset to 1.0 and must be written while idle.
module direction_blend_normalizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dbn_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dbn_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [dbn_pkg::WEIGHT_W-1:0] cfg_wdata
);
  import dbn_pkg::*;

  logic [WEIGHT_W-1:0] weight_a_r;
  logic [WEIGHT_W-1:0] weight_b_r;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic signed [COORD_W-1:0] a_c [3];
  logic signed [COORD_W-1:0] b_c [3];

  // stage 1: products and differences
  logic                     op1_r;
  logic                     wzero1_r;
  logic signed [PROD_W-1:0] prod_a_r [3];
  logic signed [PROD_W-1:0] prod_b_r [3];
  logic signed [DIFF_W-1:0] diff_r   [3];

  // stage 2: magnitudes and signs
  logic [MAG_W-1:0] mag_r [3];
  logic [2:0]       neg2_r;
  logic             deg2_r;

  // stage 3: normalized magnitudes
  logic [MAG_W-1:0]   top_mag;
  logic [SHIFT_W-1:0] shift_amt;
  logic [NORM_W-1:0]  norm_r [3];
  side_t              side3_r;

  // stage 4: squares; stage 5: sum of squares
  logic [SQ_W-1:0]  sq4_r [3];
  side_t            side4_r;
  logic [SQ_W-1:0]  sq5_r [3];
  logic [SUM_W-1:0] sum_r;
  side_t            side5_r;

  // lanes and side flags that travel with them
  side_t             mid_r [LANE_LAT];
  logic [MAGC_W-1:0] root_c [3];
  logic [UNIT_W-1:0] unit_mag [3];
  logic [UNIT_W-1:0] unit_val [3];

  // configuration writes; other indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_a_r <= WEIGHT_RESET;
      weight_b_r <= WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_A: weight_a_r <= cfg_wdata;
        REG_WEIGHT_B: weight_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance everything unless a finished item is held at the output
  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  assign a_c[0] = in_data.a_x;
  assign a_c[1] = in_data.a_y;
  assign a_c[2] = in_data.a_z;
  assign b_c[0] = in_data.b_x;
  assign b_c[1] = in_data.b_y;
  assign b_c[2] = in_data.b_z;

  // stage 1: weight each input component, or take b - a
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_data.op;
      wzero1_r <= (weight_a_r == '0) && (weight_b_r == '0);
      for (int i = 0; i < 3; i++) begin
        prod_a_r[i] <= PROD_W'(a_c[i]) * PROD_W'($signed({1'b0, weight_a_r}));
        prod_b_r[i] <= PROD_W'(b_c[i]) * PROD_W'($signed({1'b0, weight_b_r}));
        diff_r[i] <= DIFF_W'(b_c[i]) - DIFF_W'(a_c[i]);
      end
    end
  end

  // stage 2: pick the vector, split into sign and magnitude
  always_ff @(posedge clk) begin
    logic signed [VSUM_W-1:0] v;
    logic [VSUM_W-1:0]        v_abs;
    if (en) begin
      deg2_r <= (op1_r == OP_BLEND) && wzero1_r;
      for (int i = 0; i < 3; i++) begin
        if (op1_r == OP_BLEND) begin
          v = VSUM_W'(prod_a_r[i]) + VSUM_W'(prod_b_r[i]);
        end else begin
          v = VSUM_W'(diff_r[i]);
        end
        v_abs = v[VSUM_W-1] ? VSUM_W'(-v) : VSUM_W'(v);
        neg2_r[i] <= v[VSUM_W-1];
        mag_r[i] <= v_abs[MAG_W-1:0];
      end
    end
  end

  // stage 3: shift all three down until the largest fits in 31 bits
  assign top_mag = mag_r[0] | mag_r[1] | mag_r[2];

  always_comb begin
    shift_amt = '0;
    for (int b = NORM_W; b < MAG_W; b++) begin
      if (top_mag[b]) shift_amt = SHIFT_W'(b - NORM_W + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        norm_r[i] <= NORM_W'(mag_r[i] >> shift_amt);
      end
      side3_r.neg <= neg2_r;
      side3_r.deg <= deg2_r || (top_mag == '0);
    end
  end

  // stage 4: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= SQ_W'(norm_r[i]) * SQ_W'(norm_r[i]);
      end
      side4_r <= side3_r;
    end
  end

  // stage 5: squared length
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SUM_W'(sq4_r[0]) + SUM_W'(sq4_r[1]) + SUM_W'(sq4_r[2]);
      sq5_r <= sq4_r;
      side5_r <= side4_r;
    end
  end

  // per-component division and root
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      dbn_lane u_lane (
        .clk    (clk),
        .en     (en),
        .sq_i   (sq5_r[g]),
        .sum_i  (sum_r),
        .root_c (root_c[g])
      );
      assign unit_mag[g] = UNIT_W'(root_c[g]);
      assign unit_val[g] = mid_r[LANE_LAT-1].deg ? '0 :
                           mid_r[LANE_LAT-1].neg[g] ? UNIT_W'(-unit_mag[g]) : unit_mag[g];
    end
  endgenerate

  // hold sign and degenerate flags in step with the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      mid_r[0] <= side5_r;
      for (int k = 1; k < LANE_LAT; k++) begin
        mid_r[k] <= mid_r[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.unit_x <= unit_val[0];
      out_data_r.unit_y <= unit_val[1];
      out_data_r.unit_z <= unit_val[2];
      out_data_r.degenerate <= mid_r[LANE_LAT-1].deg;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

### hdl/dbn_lane.sv
// One component: quotient floor(2^30 * sq / sum) by restoring division,
// one bit per stage, then integer square root one bit per stage, then
// round: c = (isqrt + 1) / 2.
module dbn_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [dbn_pkg::SQ_W-1:0]    sq_i,
  input  logic [dbn_pkg::SUM_W-1:0]   sum_i,
  output logic [dbn_pkg::MAGC_W-1:0]  root_c
);
  import dbn_pkg::*;

  logic [SUM_W-1:0]      rem_r [DIV_STEPS];
  logic [SUM_W-1:0]      den_r [DIV_STEPS];
  logic [QUO_W-1:0]      quo_r [DIV_STEPS];
  logic [ROOT_ACC_W-1:0] op_r  [ROOT_STEPS];
  logic [ROOT_ACC_W-1:0] res_r [ROOT_STEPS];
  logic [ROOT_W:0]       round_sum;

  genvar j;
  generate
    for (j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [SUM_W-1:0] rem_src;
      logic [SUM_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic [SUM_W:0]   trial;
      logic             ge;
      logic [SUM_W:0]   diff;
      if (j == 0) begin : g_first
        // first step compares sq itself (quotient top bit set only when sq == sum)
        assign rem_src = SUM_W'(sq_i);
        assign den_src = sum_i;
        assign quo_src = '0;
        assign trial = {1'b0, rem_src};
      end else begin : g_next
        assign rem_src = rem_r[j-1];
        assign den_src = den_r[j-1];
        assign quo_src = quo_r[j-1];
        assign trial = {rem_src, 1'b0};
      end
      assign ge = trial >= {1'b0, den_src};
      assign diff = trial - {1'b0, den_src};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
          den_r[j] <= den_src;
          quo_r[j] <= {quo_src[QUO_W-2:0], ge};
        end
      end
    end

    for (j = 0; j < ROOT_STEPS; j++) begin : g_root
      localparam logic [ROOT_ACC_W-1:0] BIT = ROOT_ACC_W'(1) << (2 * (ROOT_STEPS - 1 - j));
      logic [ROOT_ACC_W-1:0] op_src;
      logic [ROOT_ACC_W-1:0] res_src;
      logic [ROOT_ACC_W-1:0] trial;
      if (j == 0) begin : g_first
        assign op_src = ROOT_ACC_W'(quo_r[DIV_STEPS-1]);
        assign res_src = '0;
      end else begin : g_next
        assign op_src = op_r[j-1];
        assign res_src = res_r[j-1];
      end
      assign trial = res_src + BIT;
      always_ff @(posedge clk) begin
        if (en) begin
          if (op_src >= trial) begin
            op_r[j] <= op_src - trial;
            res_r[j] <= (res_src >> 1) + BIT;
          end else begin
            op_r[j] <= op_src;
            res_r[j] <= res_src >> 1;
          end
        end
      end
    end
  endgenerate

  assign round_sum = (ROOT_W + 1)'(res_r[ROOT_STEPS-1][ROOT_W-1:0]) + (ROOT_W + 1)'(1);
  assign root_c = round_sum[MAGC_W:1];

endmodule

### hdl/dbn_checker.sv
module dbn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dbn_pkg::out_item_t out_data
);
  import dbn_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side stalls exactly while a result waits unread
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // degenerate results carry zero components
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0)
    else $error("degenerate result with nonzero components");

  // a unit vector is in range and never all zero
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |->
      out_data.unit_x >= -16'sd16384 && out_data.unit_x <= 16'sd16384 &&
      out_data.unit_y >= -16'sd16384 && out_data.unit_y <= 16'sd16384 &&
      out_data.unit_z >= -16'sd16384 && out_data.unit_z <= 16'sd16384 &&
      (out_data.unit_x != '0 || out_data.unit_y != '0 || out_data.unit_z != '0))
    else $error("unit vector out of range");

endmodule

bind direction_blend_normalizer dbn_checker u_dbn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
